// ===== rtl/swms_pkg.sv =====
// shared types and constants for the sliding window mean and deviation block
`default_nettype none
package swms_pkg;

  localparam int WIN_MAX  = 256;
  localparam int WIN_AW   = $clog2(WIN_MAX);
  localparam int CNT_W    = 9;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 25;
  localparam int SQS_W    = 40;
  localparam int DIV_W    = 48;
  localparam int REM_W    = 16;
  localparam int ROOT_W   = 24;
  localparam int OUT_W    = 24;

  typedef enum logic [0:0] {
    REQ_ADD   = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_t;

  typedef struct packed {
    logic                       clear;
    logic signed [SAMPLE_W-1:0] sample;
  } q_item_t;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem_init;
    logic [DIV_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_UPD,
    S_MUL_LO,
    S_MUL_HI,
    S_NUM,
    S_MDIV,
    S_MWAIT,
    S_SDIV,
    S_SWAIT,
    S_SQRT,
    S_QWAIT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/swms_front.sv =====
// request intake: classifies requests and queues them for the back end
`default_nettype none
module swms_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                req_type,
  input  wire logic signed [swms_pkg::SAMPLE_W-1:0] sample,
  output logic                                     q_valid,
  output swms_pkg::q_item_t                        q_item,
  input  wire logic                                q_pop
);
  import swms_pkg::*;

  q_item_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_stall = (fill == 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].clear  <= (req_type_t'(req_type) == REQ_CLEAR);
      entries[wr_ptr].sample <= sample;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swms_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module swms_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire swms_pkg::div_req_t req,
  output swms_pkg::div_rsp_t      rsp
);
  import swms_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic [REM_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [REM_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [REM_W:0]    trial;
  logic              qbit;
  logic [REM_W:0]    diff;
  logic [REM_W-1:0]  rem_next;

  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      quo  <= req.dividend;
      dvs  <= req.divisor;
      step <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quo  <= {quo[DIV_W-2:0], qbit};
      step <= step + STEP_W'(1);
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ===== rtl/swms_isqrt.sv =====
// iterative integer square root, one root bit per cycle
`default_nettype none
module swms_isqrt (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire swms_pkg::sqrt_req_t req,
  output swms_pkg::sqrt_rsp_t      rsp
);
  import swms_pkg::*;

  localparam int STEPS  = DIV_W / 2;
  localparam int STEP_W = $clog2(STEPS);

  logic [DIV_W-1:0]  val;
  logic [DIV_W-1:0]  root;
  logic [DIV_W-1:0]  onebit;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [DIV_W-1:0]  trial;
  logic              ge;

  always_comb begin
    trial = root + onebit;
    ge    = (val >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val    <= req.radicand;
      root   <= '0;
      onebit <= {2'b01, {(DIV_W-2){1'b0}}};
      step   <= '0;
    end else if (busy) begin
      val    <= ge ? (val - trial) : val;
      root   <= ge ? ((root >> 1) + onebit) : (root >> 1);
      onebit <= onebit >> 2;
      step   <= step + STEP_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = root[ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/swms_back.sv =====
// window state, sample memory, sequencer and result register
`default_nettype none
module swms_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [swms_pkg::CNT_W-1:0]       cfg_data,
  input  wire logic                             q_valid,
  input  wire swms_pkg::q_item_t                q_item,
  output logic                                  q_pop,
  output swms_pkg::div_req_t                    div_req,
  input  wire swms_pkg::div_rsp_t               div_rsp,
  output swms_pkg::sqrt_req_t                   sqrt_req,
  input  wire swms_pkg::sqrt_rsp_t              sqrt_rsp,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [swms_pkg::CNT_W-1:0]            held_count,
  output logic signed [swms_pkg::OUT_W-1:0]     mean_q8,
  output logic [swms_pkg::OUT_W-1:0]            std_dev_q8
);
  import swms_pkg::*;

  localparam int SQ_W   = 2 * SAMPLE_W;
  localparam int HALF_W = SQS_W / 2;
  localparam int PP_W   = CNT_W + HALF_W;
  localparam int ABS_W  = SUM_W - 1;

  function automatic logic [CNT_W-1:0] eff_len_f(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CNT_W'(WIN_MAX)) begin
      r = CNT_W'(WIN_MAX);
    end
    return r;
  endfunction

  state_t state;
  state_t state_next;

  logic signed [SAMPLE_W-1:0] mem [WIN_MAX];
  logic signed [SAMPLE_W-1:0] rd_data;

  logic [CNT_W-1:0]           eff_len;
  logic [WIN_AW-1:0]          wr_pos;
  logic [CNT_W-1:0]           held;
  logic signed [SUM_W-1:0]    sum;
  logic [SQS_W-1:0]           sumsq;

  logic signed [SAMPLE_W-1:0] cur_sample;
  logic                       replace;
  logic [SQ_W-1:0]            sq_new;
  logic [SQ_W-1:0]            sq_old;
  logic [PP_W-1:0]            p_lo;
  logic [PP_W-1:0]            p_hi;
  logic [DIV_W-1:0]           sum_sq;
  logic [DIV_W-1:0]           num;
  logic [REM_W-1:0]           den;
  logic                       mean_neg;
  logic [OUT_W-1:0]           mean_res;
  logic [OUT_W-1:0]           std_res;

  logic signed [SQ_W-1:0]     cur_ext;
  logic signed [SQ_W-1:0]     old_ext;
  logic [SUM_W-1:0]           sum_neg;
  logic [ABS_W-1:0]           sum_abs;
  logic [CNT_W:0]             pos_inc;
  logic [2*CNT_W-1:0]         den_full;
  logic [DIV_W:0]             num_full;
  logic [OUT_W-1:0]           mean_mag;
  logic                       load_out;
  logic                       accept_item;

  always_comb begin
    cur_ext  = SQ_W'(cur_sample);
    old_ext  = SQ_W'(rd_data);
    sum_neg  = -sum;
    sum_abs  = sum[SUM_W-1] ? sum_neg[ABS_W-1:0] : sum[ABS_W-1:0];
    pos_inc  = {1'b0, wr_pos} + (CNT_W+1)'(1);
    den_full = {{CNT_W{1'b0}}, held} * ({{CNT_W{1'b0}}, held} - (2*CNT_W)'(1));
    num_full = {p_hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, p_lo} - {1'b0, sum_sq};
    mean_mag = div_rsp.quotient[OUT_W-1:0];
  end

  // sequencer
  always_comb begin
    state_next        = state;
    q_pop             = 1'b0;
    accept_item       = 1'b0;
    load_out          = 1'b0;
    div_req.start     = 1'b0;
    div_req.rem_init  = '0;
    div_req.dividend  = {{(DIV_W-ABS_W-8){1'b0}}, sum_abs, 8'b0};
    div_req.divisor   = {{(REM_W-CNT_W){1'b0}}, held};
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = div_rsp.quotient;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          accept_item = 1'b1;
          state_next  = q_item.clear ? S_DONE : S_SQ;
        end
      end
      S_SQ:     state_next = S_UPD;
      S_UPD:    state_next = S_MUL_LO;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_NUM;
      S_NUM:    state_next = S_MDIV;
      S_MDIV: begin
        div_req.start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (div_rsp.done) begin
          state_next = (held > CNT_W'(1)) ? S_SDIV : S_DONE;
        end
      end
      S_SDIV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = num[DIV_W-1:DIV_W-REM_W];
        div_req.dividend = {num[DIV_W-REM_W-1:0], {REM_W{1'b0}}};
        div_req.divisor  = den;
        state_next       = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_rsp.done) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        sqrt_req.start = 1'b1;
        state_next     = S_QWAIT;
      end
      S_QWAIT: begin
        if (sqrt_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= CNT_W'(WIN_MAX);
      wr_pos  <= '0;
      held    <= '0;
      sum     <= '0;
      sumsq   <= '0;
    end else if (cfg_we) begin
      eff_len <= eff_len_f(cfg_data);
      wr_pos  <= '0;
      held    <= '0;
      sum     <= '0;
      sumsq   <= '0;
    end else if (accept_item && q_item.clear) begin
      wr_pos <= '0;
      held   <= '0;
      sum    <= '0;
      sumsq  <= '0;
    end else if (state == S_UPD) begin
      sum   <= sum + SUM_W'(cur_sample) - (replace ? SUM_W'(rd_data) : SUM_W'(0));
      sumsq <= sumsq + SQS_W'(sq_new) - SQS_W'(sq_old);
      if (!replace) begin
        held <= held + CNT_W'(1);
      end
      wr_pos <= (pos_inc == {1'b0, eff_len}) ? '0 : pos_inc[WIN_AW-1:0];
    end
  end

  // sample memory, registered read at the write position
  always_ff @(posedge clk) begin
    rd_data <= mem[wr_pos];
    if (state == S_UPD) begin
      mem[wr_pos] <= cur_sample;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_item) begin
      cur_sample <= q_item.sample;
      replace    <= (held >= eff_len);
      mean_res   <= '0;
      std_res    <= '0;
    end
    if (state == S_SQ) begin
      sq_new <= cur_ext * cur_ext;
      sq_old <= replace ? (old_ext * old_ext) : '0;
    end
    if (state == S_MUL_LO) begin
      p_lo     <= {{HALF_W{1'b0}}, held} * {{CNT_W{1'b0}}, sumsq[HALF_W-1:0]};
      sum_sq   <= {{ABS_W{1'b0}}, sum_abs} * {{ABS_W{1'b0}}, sum_abs};
      den      <= den_full[REM_W-1:0];
      mean_neg <= sum[SUM_W-1];
    end
    if (state == S_MUL_HI) begin
      p_hi <= {{HALF_W{1'b0}}, held} * {{CNT_W{1'b0}}, sumsq[SQS_W-1:HALF_W]};
    end
    if (state == S_NUM) begin
      num <= num_full[DIV_W-1:0];
    end
    if (state == S_MWAIT && div_rsp.done) begin
      mean_res <= mean_neg ? (-mean_mag) : mean_mag;
    end
    if (state == S_QWAIT && sqrt_rsp.done) begin
      std_res <= sqrt_rsp.root;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      held_count <= held;
      mean_q8    <= mean_res;
      std_dev_q8 <= std_res;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst) held <= eff_len)
    else $error("held count above window length");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wr_pos} < eff_len)
    else $error("write position outside window");

  a_empty_sums: assert property (@(posedge clk) disable iff (rst)
    (held == '0) |-> (sum == '0 && sumsq == '0))
    else $error("empty window with nonzero sums");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

// ===== rtl/sliding_window_mean_stddev_top.sv =====
// top level of the sliding window mean and sample deviation block
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------
//   in       | in_valid/in_stall  | req_type, sample
//   out      | out_valid/out_stall| held_count, mean_q8, std_dev_q8
//   config   | cfg_we             | cfg_data (window_len)
//
// an add request with two or more samples held makes two 48-step passes through
// the shared divider and one 24-step pass through the square root; with one sample
// held it makes only the mean pass through the divider, and a clear request neither
// a two-entry request queue holds up to two requests while the back end works
// and while a finished result waits in the output register
// reset (synchronous, active high) empties the window and sets the length to 256
// a config write also empties the window; the sample memory needs no clearing
`default_nettype none
module sliding_window_mean_stddev_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [swms_pkg::CNT_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 req_type,
  input  wire logic signed [swms_pkg::SAMPLE_W-1:0] sample,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [swms_pkg::CNT_W-1:0]                held_count,
  output logic signed [swms_pkg::OUT_W-1:0]         mean_q8,
  output logic [swms_pkg::OUT_W-1:0]                std_dev_q8
);
  import swms_pkg::*;

  logic      q_valid;
  q_item_t   q_item;
  logic      q_pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // intake and queue
  swms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .sample   (sample),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // shared divider for the mean and the variance quotient
  swms_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // square root of the scaled variance
  swms_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // window update, sequencing and result register
  swms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .sqrt_req   (sqrt_req),
    .sqrt_rsp   (sqrt_rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .held_count (held_count),
    .mean_q8    (mean_q8),
    .std_dev_q8 (std_dev_q8)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the sliding window mean and sample deviation block
`default_nettype none
module tb_top;
  import swms_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic signed [SAMPLE_W-1:0] sample;
  logic out_valid;
  logic out_stall;
  logic [CNT_W-1:0] held_count;
  logic signed [OUT_W-1:0] mean_q8;
  logic [OUT_W-1:0] std_dev_q8;

  sliding_window_mean_stddev_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .held_count(held_count), .mean_q8(mean_q8), .std_dev_q8(std_dev_q8)
  );

  // one pending request and one expected result
  typedef struct {
    req_type_t kind;
    logic signed [SAMPLE_W-1:0] value;
  } request_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] dev;
  } stats_t;

  request_t pending_reqs[$];
  stats_t   expected_stats[$];

  // shadow copy of the window
  logic signed [SAMPLE_W-1:0] win_mem [WIN_MAX];
  int unsigned win_wpos;
  int unsigned win_held;
  int unsigned win_len;
  longint win_sum;
  longint unsigned win_sqsum;

  int mismatches;
  bit hold_off;        // long receiver stall requested by the stimulus
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void empty_window();
    win_wpos = 0;
    win_held = 0;
    win_sum = 0;
    win_sqsum = 0;
  endfunction

  function automatic void set_window_len(logic [CNT_W-1:0] v);
    win_len = (v == 0) ? 1 : (v > WIN_MAX) ? WIN_MAX : v;
    empty_window();
  endfunction

  // apply one request to the shadow window and compute its statistics
  function automatic stats_t window_stats(request_t r);
    stats_t st;
    longint s;
    longint old;
    longint mean;
    longint unsigned sabs, num, den, q, rm, scaled, sd;
    int unsigned pos;
    st.count = '0;
    st.mean = '0;
    st.dev = '0;
    if (r.kind == REQ_CLEAR) begin
      empty_window();
    end else begin
      s = r.value;
      pos = win_wpos % win_len;
      if (win_held >= win_len) begin
        old = win_mem[pos];
        win_sum -= old;
        win_sqsum -= longint'(old * old);
      end else begin
        win_held++;
      end
      win_mem[pos] = r.value;
      win_sum += s;
      win_sqsum += longint'(s * s);
      win_wpos = (pos + 1) % win_len;
    end
    st.count = win_held[CNT_W-1:0];
    if (win_held > 0) begin
      mean = (win_sum * 256) / longint'(win_held);
      st.mean = mean[OUT_W-1:0];
      if (win_held > 1) begin
        sabs = (win_sum < 0) ? -win_sum : win_sum;
        num = longint'(win_held) * win_sqsum - sabs * sabs;
        den = longint'(win_held) * longint'(win_held - 1);
        q = num / den;
        rm = num % den;
        scaled = (q << 16) + ((rm << 16) / den);
        sd = int_sqrt(scaled);
        st.dev = (sd > 64'hFFFFFF) ? 24'hFFFFFF : sd[OUT_W-1:0];
      end
    end
    return st;
  endfunction

  // driver: pops pending requests, a random gap or none before each one
  int gap_left;
  initial gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      // accepted this edge, predict it now
      expected_stats.push_back(window_stats('{kind: req_type_t'(req_type), value: sample}));
      if (pending_reqs.size() > 0 && $urandom_range(0, 13) == 0 && gap_left == 0) begin
        // back-to-back request, keep valid high
        req_type <= pending_reqs[0].kind;
        sample <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end
    end else if (!in_valid && pending_reqs.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        in_valid <= 1'b1;
        req_type <= pending_reqs[0].kind;
        sample <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
      end
    end
  end

  // monitor: checks each result, random stall per result
  int stall_left;
  initial stall_left = 0;
  always @(posedge clk) begin
    stats_t exp_st;
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: count %0d mean %0d dev %0d",
                     held_count, mean_q8, std_dev_q8);
        end else begin
          exp_st = expected_stats.pop_front();
          if (held_count !== exp_st.count || mean_q8 !== exp_st.mean ||
              std_dev_q8 !== exp_st.dev) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: count %0d/%0d mean %0d/%0d dev %0d/%0d (exp/act)",
                       exp_st.count, held_count, $signed(exp_st.mean), mean_q8,
                       exp_st.dev, std_dev_q8);
          end
        end
        stall_left = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      if (hold_off) begin
        // long hold-off counted here while the sender keeps offering
        hold_cycles++;
        out_stall <= 1'b1;
        if (hold_cycles >= 2000) begin
          hold_off = 1'b0;
          hold_cycles = 0;
        end
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_req(req_type_t k, logic signed [SAMPLE_W-1:0] v);
    pending_reqs.push_back('{kind: k, value: v});
  endtask

  // wait until every request is through, then let the block settle
  // sampled at the falling edge so the driver's updates have landed
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_stats.size() > 0)
      @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_len(logic [CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_window_len(v);
  endtask

  // random phase: mostly adds, rare clears
  task automatic random_reqs(int cnt);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 60) == 0)
        queue_req(REQ_CLEAR, 16'($urandom));
      else if ($urandom_range(0, 3) == 0)
        queue_req(REQ_ADD, $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000);
      else
        queue_req(REQ_ADD, 16'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    sample = '0;
    out_stall = 1'b1;
    mismatches = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    set_window_len(9'd256);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty window, single sample, extremes, clear
    queue_req(REQ_CLEAR, 16'sh0);
    queue_req(REQ_ADD, 16'sh7FFF);
    queue_req(REQ_ADD, -16'sh8000);
    queue_req(REQ_ADD, -16'sh8000);
    queue_req(REQ_ADD, 16'sh7FFF);
    queue_req(REQ_ADD, 16'sh0);
    queue_req(REQ_ADD, -16'sh1);
    queue_req(REQ_CLEAR, 16'shFFFF);
    queue_req(REQ_ADD, 16'sh5555);
    queue_req(REQ_ADD, -16'sh5556);
    queue_req(REQ_CLEAR, 16'sh0);
    drain();

    // length 1: deviation always zero, window wraps every sample
    write_len(9'd1);
    queue_req(REQ_ADD, 16'sh1234);
    queue_req(REQ_ADD, -16'sh8000);
    queue_req(REQ_ADD, 16'sh7FFF);
    drain();

    // zero and oversize lengths saturate
    write_len(9'd0);
    random_reqs(20);
    drain();
    write_len(9'h1FF);
    random_reqs(300);
    drain();

    // windows of several lengths; a long output hold-off in the first one fills the queue
    write_len(9'd3);
    hold_off = 1'b1;
    random_reqs(150);
    drain();
    write_len(9'd17);
    random_reqs(250);
    drain();
    write_len(9'd2);
    random_reqs(150);
    drain();
    write_len(9'd256);
    random_reqs(380);
    drain();
    write_len(9'd100);
    random_reqs(280);
    drain();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/swms_pkg.sv
rtl/swms_front.sv
rtl/swms_div.sv
rtl/swms_isqrt.sv
rtl/swms_back.sv
rtl/sliding_window_mean_stddev_top.sv
tb/tb_top.sv
